// File: hdl/psdc_pkg.sv
// ----------------------------------------------------------------------------
// psdc_pkg
// Shared widths, register indexes, codes and controller/datapath link types
// for the pedal sensor direction classifier.
// ----------------------------------------------------------------------------
package psdc_pkg;

   // time base and field widths
   localparam int TIME_W    = 32;
   localparam int STAMP_W   = 32;
   localparam int TICK_W    = 20;
   localparam int FREQ_W    = 20;
   localparam int DUTY_W    = 15;
   localparam int IDLE_W    = 16;
   localparam int DIR_W     = 2;
   localparam int FREQ_FRAC = 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_THR     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_THR     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = CSR_IDX_W'(3);

   // register reset values
   localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(10000);
   localparam logic [FREQ_W-1:0] FREQ_THR_RESET  = FREQ_W'(205);
   localparam logic [DUTY_W-1:0] DUTY_THR_RESET  = DUTY_W'(11520);
   localparam logic [IDLE_W-1:0] IDLE_TO_RESET   = IDLE_W'(600);

   // fixed point limits
   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(25600);
   localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;

   // shared divider geometry
   localparam int DIV_BITS_W = TICK_W + FREQ_FRAC;
   localparam int DIV_D_W    = TIME_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_BITS_W + 1);

   // item command codes
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [DIR_W-1:0] {
      DIR_NONE     = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2,
      DIR_UNSPEC   = 2'd3
   } dir_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic edge_setup;
      logic freq_start;
      logic freq_store;
      logic duty_load;
      logic duty_start;
      logic mean_freq_store;
      logic mean_duty_store;
      logic eval_store;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_eval;
      logic level_changed;
      logic div_busy;
   } status_type;

endpackage

// File: hdl/psdc_req_if.sv
// ----------------------------------------------------------------------------
// psdc_req_if
// Input channel: edge events and evaluation ticks with valid/ready.
// ----------------------------------------------------------------------------
interface psdc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic                         pin_level;
   logic [psdc_pkg::STAMP_W-1:0] time_stamp;

   modport source (output valid, command, pin_level, time_stamp, input ready);
   modport sink   (input valid, command, pin_level, time_stamp, output ready);
endinterface

// File: hdl/psdc_rsp_if.sv
// ----------------------------------------------------------------------------
// psdc_rsp_if
// Result channel: direction and averaged frequency and duty with valid/ready.
// ----------------------------------------------------------------------------
interface psdc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [psdc_pkg::DIR_W-1:0]  direction;
   logic [psdc_pkg::FREQ_W-1:0] avg_frequency;
   logic [psdc_pkg::DUTY_W-1:0] avg_duty;

   modport source (output valid, direction, avg_frequency, avg_duty, input ready);
   modport sink   (input valid, direction, avg_frequency, avg_duty, output ready);
endinterface

// File: hdl/psdc_div.sv
// ----------------------------------------------------------------------------
// psdc_div
// Shared restoring divider, one quotient bit per cycle. The caller preloads
// the partial remainder, the dividend bits still to shift in and the count.
// ----------------------------------------------------------------------------
module psdc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [psdc_pkg::DIV_D_W-1:0]     rem_init,
   input  logic [psdc_pkg::DIV_BITS_W-1:0]  bits_init,
   input  logic [psdc_pkg::DIV_CNT_W-1:0]   steps,
   input  logic [psdc_pkg::DIV_D_W-1:0]     divisor,
   output logic                             busy,
   output logic [psdc_pkg::DIV_BITS_W-1:0]  quotient
);

   logic                            busy_ff, busy_in;
   logic [psdc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [psdc_pkg::DIV_D_W-1:0]    rem_ff, rem_in;
   logic [psdc_pkg::DIV_D_W-1:0]    div_ff, div_in;
   logic [psdc_pkg::DIV_BITS_W-1:0] bits_ff, bits_in;
   logic [psdc_pkg::DIV_BITS_W-1:0] quot_ff, quot_in;
   logic [psdc_pkg::DIV_D_W:0]      trial;
   logic [psdc_pkg::DIV_D_W:0]      diff;
   logic                            fits;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, bits_ff[psdc_pkg::DIV_BITS_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   // load on start, then advance one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         div_in  = divisor;
         bits_in = bits_init;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[psdc_pkg::DIV_D_W-1:0] : trial[psdc_pkg::DIV_D_W-1:0];
         bits_in = {bits_ff[psdc_pkg::DIV_BITS_W-2:0], 1'b0};
         quot_in = {quot_ff[psdc_pkg::DIV_BITS_W-2:0], fits};
         cnt_in  = cnt_ff - psdc_pkg::DIV_CNT_W'(1);
         if (cnt_ff == psdc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// File: hdl/psdc_datapath.sv
// ----------------------------------------------------------------------------
// psdc_datapath
// Configuration registers, edge timing state, frequency and duty arithmetic,
// running means, direction decision and the result register.
// ----------------------------------------------------------------------------
module psdc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  psdc_pkg::cmd_type               cmd,
   output psdc_pkg::status_type            status,
   input  logic                            req_command,
   input  logic                            req_pin_level,
   input  logic [psdc_pkg::STAMP_W-1:0]    req_time_stamp,
   input  logic                            csr_write,
   input  logic [psdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psdc_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [psdc_pkg::DIR_W-1:0]      rsp_direction,
   output logic [psdc_pkg::FREQ_W-1:0]     rsp_avg_frequency,
   output logic [psdc_pkg::DUTY_W-1:0]     rsp_avg_duty
);

   localparam int TW     = psdc_pkg::TIME_W;
   localparam int PROD_W = psdc_pkg::TIME_W + psdc_pkg::DUTY_W;
   localparam int MEAN_W = psdc_pkg::FREQ_W + 2;
   localparam int MUL_W  = 2 * MEAN_W + 1;
   localparam logic [MEAN_W:0] DIV3_K =
      (MEAN_W + 1)'(((64'd1 << (MEAN_W + 1)) + 64'd1) / 64'd3);

   // floor(v / 3) by reciprocal multiply, exact for v below 2^MEAN_W
   function automatic logic [MEAN_W-1:0] div3(input logic [MEAN_W-1:0] v);
      logic [MUL_W-1:0] p;
      p = MUL_W'(v) * MUL_W'(DIV3_K);
      return p[MUL_W-1:MEAN_W+1];
   endfunction

   // configuration
   logic [psdc_pkg::TICK_W-1:0] tick_rate_ff;
   logic [psdc_pkg::FREQ_W-1:0] freq_thr_ff;
   logic [psdc_pkg::DUTY_W-1:0] duty_thr_ff;
   logic [psdc_pkg::IDLE_W-1:0] idle_to_ff;

   // captured item
   logic          is_eval_ff;
   logic          lvl_ff;
   logic [TW-1:0] ts_ff;

   // edge state
   logic                        prev_level_ff;
   logic [TW-1:0]               last_edge_ff;
   logic [TW-1:0]               last_fall_ff;
   logic [TW-1:0]               last_rise_ff;
   logic [TW-1:0]               high_ff;
   logic [TW-1:0]               low_ff;
   logic [psdc_pkg::FREQ_W-1:0] inst_freq_ff, inst_freq_in;
   logic [psdc_pkg::FREQ_W-1:0] mean_freq_ff, mean_freq_in;
   logic [psdc_pkg::DUTY_W-1:0] mean_duty_ff, mean_duty_in;

   // duty operands
   logic [PROD_W-1:0]            prod_ff;
   logic [psdc_pkg::DIV_D_W-1:0] sum_ff;

   // result register
   logic [psdc_pkg::DIR_W-1:0]  out_dir_ff;
   logic [psdc_pkg::FREQ_W-1:0] out_freq_ff;
   logic [psdc_pkg::DUTY_W-1:0] out_duty_ff;

   // combinational helpers
   logic                              falling, rising;
   logic [TW-1:0]                     period;
   logic [TW-1:0]                     elapsed;
   logic                              timed_out;
   psdc_pkg::dir_type                 dir_val;
   logic [psdc_pkg::DUTY_W-1:0]       duty_val;
   logic [MEAN_W-1:0]                 mean_freq_sum, mean_duty_sum;
   logic [MEAN_W-1:0]                 mean_freq_q, mean_duty_q;
   logic                              div_start;
   logic [psdc_pkg::DIV_D_W-1:0]      div_rem_init;
   logic [psdc_pkg::DIV_BITS_W-1:0]   div_bits_init;
   logic [psdc_pkg::DIV_CNT_W-1:0]    div_steps;
   logic [psdc_pkg::DIV_D_W-1:0]      div_divisor;
   logic                              div_busy;
   logic [psdc_pkg::DIV_BITS_W-1:0]   div_quot;

   // classify the edge and pick the period
   always_comb begin
      falling = !lvl_ff && prev_level_ff;
      rising  = lvl_ff && !prev_level_ff;
      period  = falling ? (ts_ff - last_fall_ff) : (ts_ff - last_rise_ff);
   end

   // steer the shared divider to frequency or duty
   always_comb begin
      div_start     = cmd.freq_start || cmd.duty_start;
      div_rem_init  = '0;
      div_bits_init = {tick_rate_ff, psdc_pkg::FREQ_FRAC'(0)};
      div_steps     = psdc_pkg::DIV_CNT_W'(psdc_pkg::DIV_BITS_W);
      div_divisor   = {1'b0, period};
      if (cmd.duty_start) begin
         div_rem_init  = psdc_pkg::DIV_D_W'(prod_ff[PROD_W-1:psdc_pkg::DUTY_W]);
         div_bits_init = {prod_ff[psdc_pkg::DUTY_W-1:0],
                          (psdc_pkg::DIV_BITS_W - psdc_pkg::DUTY_W)'(0)};
         div_steps     = psdc_pkg::DIV_CNT_W'(psdc_pkg::DUTY_W);
         div_divisor   = sum_ff;
      end
   end

   psdc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .rem_init  (div_rem_init),
      .bits_init (div_bits_init),
      .steps     (div_steps),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quot)
   );

   // means and the direction decision
   always_comb begin
      duty_val      = (sum_ff == '0) ? '0 : div_quot[psdc_pkg::DUTY_W-1:0];
      mean_freq_sum = MEAN_W'({mean_freq_ff, 1'b0}) + MEAN_W'(inst_freq_ff);
      mean_duty_sum = MEAN_W'({mean_duty_ff, 1'b0}) + MEAN_W'(duty_val);
      mean_freq_q   = div3(mean_freq_sum);
      mean_duty_q   = div3(mean_duty_sum);
      elapsed       = ts_ff - last_edge_ff;
      timed_out     = (elapsed > TW'(idle_to_ff));
      dir_val       = psdc_pkg::DIR_UNSPEC;
      if (mean_freq_ff > freq_thr_ff) begin
         dir_val = (mean_duty_ff > duty_thr_ff) ? psdc_pkg::DIR_FORWARD
                                                : psdc_pkg::DIR_BACKWARD;
      end
      if (timed_out) begin
         dir_val = psdc_pkg::DIR_NONE;
      end
   end

   // next values of frequency and means
   always_comb begin
      inst_freq_in = inst_freq_ff;
      mean_freq_in = mean_freq_ff;
      mean_duty_in = mean_duty_ff;
      if (cmd.freq_store) begin
         inst_freq_in = (|div_quot[psdc_pkg::DIV_BITS_W-1:psdc_pkg::FREQ_W])
                        ? psdc_pkg::FREQ_MAX : div_quot[psdc_pkg::FREQ_W-1:0];
      end
      if (cmd.mean_freq_store) begin
         mean_freq_in = mean_freq_q[psdc_pkg::FREQ_W-1:0];
      end
      if (cmd.mean_duty_store) begin
         mean_duty_in = mean_duty_q[psdc_pkg::DUTY_W-1:0];
      end
      if (cmd.eval_store && timed_out) begin
         inst_freq_in = '0;
         mean_freq_in = '0;
         mean_duty_in = '0;
      end
   end

   // configuration and edge state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff  <= psdc_pkg::TICK_RATE_RESET;
         freq_thr_ff   <= psdc_pkg::FREQ_THR_RESET;
         duty_thr_ff   <= psdc_pkg::DUTY_THR_RESET;
         idle_to_ff    <= psdc_pkg::IDLE_TO_RESET;
         prev_level_ff <= 1'b0;
         last_edge_ff  <= '0;
         last_fall_ff  <= '0;
         last_rise_ff  <= '0;
         high_ff       <= TW'(1);
         low_ff        <= TW'(1);
         inst_freq_ff  <= '0;
         mean_freq_ff  <= '0;
         mean_duty_ff  <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               psdc_pkg::CSR_TICK_RATE:    tick_rate_ff <= csr_data[psdc_pkg::TICK_W-1:0];
               psdc_pkg::CSR_FREQ_THR:     freq_thr_ff  <= csr_data[psdc_pkg::FREQ_W-1:0];
               psdc_pkg::CSR_DUTY_THR:     duty_thr_ff  <= csr_data[psdc_pkg::DUTY_W-1:0];
               psdc_pkg::CSR_IDLE_TIMEOUT: idle_to_ff   <= csr_data[psdc_pkg::IDLE_W-1:0];
               default: ;
            endcase
         end
         if (cmd.edge_setup) begin
            if (falling) begin
               last_fall_ff <= ts_ff;
               high_ff      <= ts_ff - last_rise_ff;
            end
            if (rising) begin
               last_rise_ff <= ts_ff;
               low_ff       <= ts_ff - last_fall_ff;
            end
            prev_level_ff <= lvl_ff;
            last_edge_ff  <= ts_ff;
         end
         inst_freq_ff <= inst_freq_in;
         mean_freq_ff <= mean_freq_in;
         mean_duty_ff <= mean_duty_in;
      end
   end

   // item capture, duty operands and the result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_eval_ff <= (req_command == psdc_pkg::CMD_EVAL);
         lvl_ff     <= req_pin_level;
         ts_ff      <= TW'(req_time_stamp);
      end
      if (cmd.duty_load) begin
         prod_ff <= PROD_W'(high_ff) * PROD_W'(psdc_pkg::DUTY_FULL);
         sum_ff  <= {1'b0, high_ff} + {1'b0, low_ff};
      end
      if (cmd.eval_store) begin
         out_dir_ff  <= dir_val;
         out_freq_ff <= timed_out ? '0 : mean_freq_ff;
         out_duty_ff <= timed_out ? '0 : mean_duty_ff;
      end
   end

   always_comb begin
      status.is_eval       = is_eval_ff;
      status.level_changed = (lvl_ff != prev_level_ff);
      status.div_busy      = div_busy;
   end

   assign rsp_direction     = out_dir_ff;
   assign rsp_avg_frequency = out_freq_ff;
   assign rsp_avg_duty      = out_duty_ff;

endmodule

// File: hdl/psdc_ctrl.sv
// ----------------------------------------------------------------------------
// psdc_ctrl
// Sequencer: takes one item at a time, walks the edge path through the
// shared divider, and issues evaluations into the result register.
// ----------------------------------------------------------------------------
module psdc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output psdc_pkg::cmd_type     cmd,
   input  psdc_pkg::status_type  status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EDGE,
      ST_FREQ_WAIT,
      ST_DUTY_MUL,
      ST_DUTY_DIV,
      ST_DUTY_WAIT,
      ST_MEAN_FREQ,
      ST_MEAN_DUTY,
      ST_EVAL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // decode commands and the next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.is_eval ? ST_EVAL : ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edge_setup = 1'b1;
            cmd.freq_start = status.level_changed;
            state_in       = status.level_changed ? ST_FREQ_WAIT : ST_DUTY_MUL;
         end
         ST_FREQ_WAIT: begin
            if (!status.div_busy) begin
               cmd.freq_store = 1'b1;
               state_in       = ST_DUTY_MUL;
            end
         end
         ST_DUTY_MUL: begin
            cmd.duty_load = 1'b1;
            state_in      = ST_DUTY_DIV;
         end
         ST_DUTY_DIV: begin
            cmd.duty_start = 1'b1;
            state_in       = ST_DUTY_WAIT;
         end
         ST_DUTY_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_MEAN_FREQ;
            end
         end
         ST_MEAN_FREQ: begin
            cmd.mean_freq_store = 1'b1;
            state_in            = ST_MEAN_DUTY;
         end
         ST_MEAN_DUTY: begin
            cmd.mean_duty_store = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_EVAL: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.eval_store = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/pedal_sensor_direction_classifier.sv
// Evaluate item: DECODE, then EVAL stores the result once the result register is free.
// Edge item: EDGE, FREQ_WAIT on a level change, DUTY_MUL, DUTY_DIV, DUTY_WAIT, MEAN_FREQ,
// MEAN_DUTY; the shared one-bit-per-cycle divider runs 28 steps for frequency, 15 for duty.
// One item is in work at a time; a waiting result holds only an evaluate item in EVAL.
// Synchronous active-high reset restores register defaults and resets the edge timing state.
// ----------------------------------------------------------------------------
// pedal_sensor_direction_classifier
// Top level: controller, datapath and channel wiring for the pedal sensor
// direction classifier.
// ----------------------------------------------------------------------------
module pedal_sensor_direction_classifier (
   input  logic                            clock,
   input  logic                            reset,
   psdc_req_if.sink                        req_ch,
   psdc_rsp_if.source                      rsp_ch,
   input  logic                            csr_write,
   input  logic [psdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psdc_pkg::CSR_DATA_W-1:0] csr_data
);

   psdc_pkg::cmd_type    cmd;
   psdc_pkg::status_type status;

   psdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   psdc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_ch.command),
      .req_pin_level     (req_ch.pin_level),
      .req_time_stamp    (req_ch.time_stamp),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_direction     (rsp_ch.direction),
      .rsp_avg_frequency (rsp_ch.avg_frequency),
      .rsp_avg_duty      (rsp_ch.avg_duty)
   );

endmodule

// File: tb/sv/pedal_sensor_direction_classifier_tb.sv
// ----------------------------------------------------------------------------
// pedal_sensor_direction_classifier_tb
// Self-checking bench for the pedal sensor direction classifier. Edge events
// and evaluation ticks go in over the request channel, with random gaps in most runs. A
// local model of frequency, duty and the running means predicts every
// direction report. The result channel stalls at random, and each report is
// compared field by field with the oldest prediction. Register settings
// change only while the block is idle, from the reset values to the extremes
// and to random values.
// ----------------------------------------------------------------------------
module pedal_sensor_direction_classifier_tb;
   import psdc_pkg::*;

   localparam int          SETTLE_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   typedef struct {
      dir_type           direction;
      bit [FREQ_W-1:0]   avg_frequency;
      bit [DUTY_W-1:0]   avg_duty;
   } direction_report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   psdc_req_if req_ch ();
   psdc_rsp_if rsp_ch ();

   pedal_sensor_direction_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // register copies
   bit [TICK_W-1:0]  cfg_tick_rate    = TICK_RATE_RESET;
   bit [FREQ_W-1:0]  cfg_freq_thr     = FREQ_THR_RESET;
   bit [DUTY_W-1:0]  cfg_duty_thr     = DUTY_THR_RESET;
   bit [IDLE_W-1:0]  cfg_idle_timeout = IDLE_TO_RESET;

   // sensor timing state
   bit               level_q    = 1'b0;
   bit [TIME_W-1:0]  edge_at    = '0;
   bit [TIME_W-1:0]  fall_at    = '0;
   bit [TIME_W-1:0]  rise_at    = '0;
   bit [TIME_W-1:0]  high_span  = TIME_W'(1);
   bit [TIME_W-1:0]  low_span   = TIME_W'(1);
   bit [FREQ_W-1:0]  inst_freq  = '0;
   bit [FREQ_W-1:0]  mean_freq  = '0;
   bit [DUTY_W-1:0]  mean_duty  = '0;

   direction_report_type  reports_due [$];
   direction_report_type  due;
   int               err_count   = 0;
   int unsigned      cycle_count = 0;
   bit               idle_gaps   = 1'b1;
   int               stall_left  = 0;

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // Q12.8 frequency from a period in ticks, saturating
   function automatic bit [FREQ_W-1:0] freq_of_period(input bit [TIME_W-1:0] period);
      longint unsigned num;
      longint unsigned quot;
      if (period == '0)
         return FREQ_MAX;
      num  = 64'(cfg_tick_rate);
      num  = num << FREQ_FRAC;
      quot = num / 64'(period);
      return (quot > FREQ_MAX) ? FREQ_MAX : FREQ_W'(quot);
   endfunction

   // Q7.8 percent high share; the sum is taken without overflow
   function automatic bit [DUTY_W-1:0] duty_of_times(input bit [TIME_W-1:0] hi_t,
                                                    input bit [TIME_W-1:0] lo_t);
      longint unsigned total;
      longint unsigned num;
      total = 64'(hi_t);
      total = total + 64'(lo_t);
      if (total == 0)
         return '0;
      num = 64'(hi_t);
      num = num * 64'(DUTY_FULL);
      return DUTY_W'(num / total);
   endfunction

   function automatic longint unsigned blend3(input longint unsigned mean,
                                              input longint unsigned sample);
      return (2 * mean + sample) / 3;
   endfunction

   // advance the sensor state for one transfer; queue a report on evaluate
   function automatic void classify_item(input bit cmd, input bit lvl,
                                         input bit [TIME_W-1:0] stamp);
      direction_report_type rep;
      bit [TIME_W-1:0] quiet_span;
      if (cmd == CMD_EDGE) begin
         if (lvl == 1'b0 && level_q == 1'b1) begin
            inst_freq = freq_of_period(stamp - fall_at);
            fall_at   = stamp;
            high_span = stamp - rise_at;
         end else if (lvl == 1'b1 && level_q == 1'b0) begin
            inst_freq = freq_of_period(stamp - rise_at);
            rise_at   = stamp;
            low_span  = stamp - fall_at;
         end
         mean_freq = FREQ_W'(blend3(mean_freq, inst_freq));
         mean_duty = DUTY_W'(blend3(mean_duty, duty_of_times(high_span, low_span)));
         level_q   = lvl;
         edge_at   = stamp;
      end else begin
         rep.direction = DIR_UNSPEC;
         if (mean_freq > cfg_freq_thr)
            rep.direction = (mean_duty > cfg_duty_thr) ? DIR_FORWARD : DIR_BACKWARD;
         quiet_span = stamp - edge_at;
         if (quiet_span > TIME_W'(cfg_idle_timeout)) begin
            rep.direction = DIR_NONE;
            inst_freq     = '0;
            mean_freq     = '0;
            mean_duty     = '0;
         end
         rep.avg_frequency = mean_freq;
         rep.avg_duty      = mean_duty;
         reports_due.push_back(rep);
      end
   endfunction

   // ------------------------------------------------------------------------
   // channel helpers
   // ------------------------------------------------------------------------

   // mostly short pauses, a few long ones
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // drive one item and hold it until the transfer
   task automatic send_item(input bit cmd, input bit lvl, input bit [TIME_W-1:0] stamp);
      int gap;
      gap = idle_gaps ? pick_pause() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.pin_level  <= lvl;
      req_ch.time_stamp <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      classify_item(cmd, lvl, stamp);
   endtask

   // drop valid, wait for every report, then let the block go quiet
   task automatic quiesce(input int tail);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (reports_due.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   // write all four registers while the block is idle
   task automatic load_settings(input bit [TICK_W-1:0] tick, input bit [FREQ_W-1:0] freq_thr,
                                input bit [DUTY_W-1:0] duty_thr, input bit [IDLE_W-1:0] idle);
      bit [CSR_IDX_W-1:0]  idx [4];
      bit [CSR_DATA_W-1:0] val [4];
      idx = '{CSR_TICK_RATE, CSR_FREQ_THR, CSR_DUTY_THR, CSR_IDLE_TIMEOUT};
      val = '{CSR_DATA_W'(tick), CSR_DATA_W'(freq_thr), CSR_DATA_W'(duty_thr),
              CSR_DATA_W'(idle)};
      quiesce(SETTLE_CYCLES);
      foreach (idx[i]) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
      end
      csr_write        <= 1'b0;
      cfg_tick_rate    = tick;
      cfg_freq_thr     = freq_thr;
      cfg_duty_thr     = duty_thr;
      cfg_idle_timeout = idle;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset settings: empty means, timeout, repeated level, zero period,
   // forward and backward patterns, timestamp wrap
   task automatic test_edge_cases();
      send_item(CMD_EVAL, 1'b1, 32'd0);
      send_item(CMD_EVAL, 1'b0, 32'd601);
      send_item(CMD_EDGE, 1'b1, 32'd100);
      send_item(CMD_EDGE, 1'b0, 32'd100);
      send_item(CMD_EDGE, 1'b1, 32'd100);
      send_item(CMD_EDGE, 1'b1, 32'd130);
      send_item(CMD_EVAL, 1'b0, 32'd140);
      // high 300, low 100: forward
      send_item(CMD_EDGE, 1'b0, 32'd430);
      send_item(CMD_EDGE, 1'b1, 32'd530);
      send_item(CMD_EDGE, 1'b0, 32'd830);
      send_item(CMD_EDGE, 1'b1, 32'd930);
      send_item(CMD_EDGE, 1'b0, 32'd1230);
      send_item(CMD_EVAL, 1'b1, 32'd1300);
      // high 100, low 300: backward, then time out
      send_item(CMD_EDGE, 1'b1, 32'd1330);
      send_item(CMD_EDGE, 1'b0, 32'd1430);
      send_item(CMD_EDGE, 1'b1, 32'd1730);
      send_item(CMD_EDGE, 1'b0, 32'd1830);
      send_item(CMD_EDGE, 1'b1, 32'd2130);
      send_item(CMD_EDGE, 1'b0, 32'd2230);
      send_item(CMD_EVAL, 1'b0, 32'd2300);
      send_item(CMD_EVAL, 1'b1, 32'd2831);
      // wrap of the time base
      send_item(CMD_EDGE, 1'b1, 32'hFFFF_FF00);
      send_item(CMD_EDGE, 1'b0, 32'hFFFF_FFFF);
      send_item(CMD_EDGE, 1'b1, 32'h0000_0040);
      send_item(CMD_EVAL, 1'b0, 32'h0000_0050);
   endtask

   // zero tick rate: frequency 0 except on a zero period
   task automatic test_zero_tick_rate();
      load_settings('0, '0, DUTY_THR_RESET, 16'd1000);
      send_item(CMD_EDGE, 1'b0, 32'd10000);
      send_item(CMD_EDGE, 1'b1, 32'd10050);
      send_item(CMD_EDGE, 1'b0, 32'd10100);
      send_item(CMD_EVAL, 1'b1, 32'd10120);
      send_item(CMD_EDGE, 1'b1, 32'd10150);
      send_item(CMD_EDGE, 1'b0, 32'd10100);
      send_item(CMD_EVAL, 1'b0, 32'd10200);
   endtask

   // pedalling patterns with random content, plus evaluations and noise
   task automatic test_pedal_traffic(input int count, input bit with_gaps);
      int              span;
      int              hi_len;
      int              lo_len;
      int              pick;
      bit              lvl;
      bit [TIME_W-1:0] base;
      idle_gaps = with_gaps;
      span      = (cfg_idle_timeout < 8) ? 8 : int'(cfg_idle_timeout);
      hi_len    = 1;
      lo_len    = 1;
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) begin
            hi_len = $urandom_range(1, span);
            lo_len = $urandom_range(1, span);
         end
         // hold the sender until every report is back
         if (k == count / 2)
            quiesce(0);
         pick = $urandom_range(0, 99);
         base = edge_at;
         lvl  = !level_q;
         if (pick < 58)
            send_item(CMD_EDGE, lvl, base + (lvl ? lo_len : hi_len) + $urandom_range(0, 3));
         else if (pick < 66)
            send_item(CMD_EDGE, level_q, base + $urandom_range(0, span / 4));
         else if (pick < 68)
            send_item(CMD_EDGE, lvl, lvl ? rise_at : fall_at);
         else if (pick < 86)
            send_item(CMD_EVAL, 1'($urandom), base + $urandom_range(0, cfg_idle_timeout));
         else if (pick < 89)
            send_item(CMD_EVAL, 1'($urandom),
                      base + cfg_idle_timeout + $urandom_range(0, 2));
         else if (pick < 92)
            send_item(CMD_EVAL, 1'($urandom),
                      base + cfg_idle_timeout + $urandom_range(0, 5000));
         else if (pick < 93)
            send_item(CMD_EDGE, lvl, 32'hFFFF_FFFF - $urandom_range(0, 2 * span));
         else
            send_item(1'($urandom), 1'($urandom), $urandom);
      end
      idle_gaps = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // result checking and receiver stalls
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (reports_due.size() == 0) begin
            $error("direction report with none expected: %0d %0d %0d",
                   rsp_ch.direction, rsp_ch.avg_frequency, rsp_ch.avg_duty);
            err_count++;
         end else begin
            due = reports_due.pop_front();
            if (rsp_ch.direction !== due.direction) begin
               $error("direction: expected %0d, got %0d", due.direction, rsp_ch.direction);
               err_count++;
            end
            if (rsp_ch.avg_frequency !== due.avg_frequency) begin
               $error("avg_frequency: expected %0d, got %0d",
                      due.avg_frequency, rsp_ch.avg_frequency);
               err_count++;
            end
            if (rsp_ch.avg_duty !== due.avg_duty) begin
               $error("avg_duty: expected %0d, got %0d", due.avg_duty, rsp_ch.avg_duty);
               err_count++;
            end
         end
      end
      // stall the result side now and then
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (idle_gaps && $urandom_range(0, 99) < 30)
            stall_left = pick_pause();
      end
   end

   // guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL pedal_sensor_direction_classifier");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      csr_write         <= 1'b0;
      csr_index         <= CSR_TICK_RATE;
      csr_data          <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_EDGE;
      req_ch.pin_level  <= 1'b0;
      req_ch.time_stamp <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_zero_tick_rate();

      load_settings(TICK_RATE_RESET, FREQ_THR_RESET, DUTY_THR_RESET, IDLE_TO_RESET);
      test_pedal_traffic(300, 1'b1);

      load_settings(TICK_W'($urandom_range(1, 1000000)), FREQ_W'($urandom_range(0, 4000)),
                    DUTY_W'($urandom_range(0, 25600)), IDLE_W'($urandom_range(0, 65535)));
      test_pedal_traffic(250, 1'b0);

      load_settings(20'd1000000, '0, DUTY_FULL, '1);
      test_pedal_traffic(200, 1'b1);

      load_settings(20'd1, FREQ_MAX, '0, '0);
      test_pedal_traffic(200, 1'b1);

      load_settings(TICK_W'($urandom_range(1, 1000000)),
                    FREQ_W'($urandom_range(0, 20'hFFFFF)),
                    DUTY_W'($urandom_range(0, 25600)),
                    IDLE_W'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 65535)));
      test_pedal_traffic(300, 1'b1);

      quiesce(SETTLE_CYCLES);
      if (err_count == 0)
         $display("PASS pedal_sensor_direction_classifier");
      else
         $display("FAIL pedal_sensor_direction_classifier");
      $finish;
   end

endmodule
